// File: rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the block range set RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define BRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("block range set assertion failed");

// The expression must never be true outside reset.
`define BRS_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("block range set forbidden condition");

`endif

// File: rtl/brs_pkg.sv
// -----------------------------------------------------------------------------
// brs_pkg
// Types and codes shared by the block range set logic.
// -----------------------------------------------------------------------------
package brs_pkg;

  // Block numbers are this wide; the covered count needs one more bit.
  localparam int unsigned BLOCK_BITS = 32;
  localparam int unsigned TOTAL_BITS = BLOCK_BITS + 1;
  localparam int unsigned COUNT_BITS = 7;

  // Command opcodes. The last code is unassigned and is answered as a no-op.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [BLOCK_BITS-1:0] first_block;
    logic [BLOCK_BITS-1:0] last_block;
    logic [BLOCK_BITS-1:0] probe_block;
  } brs_cmd_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  present;
    logic [TOTAL_BITS-1:0] total_blocks;
    logic [COUNT_BITS-1:0] range_count;
  } brs_result_t;

endpackage

// File: rtl/block_range_set.sv
// -----------------------------------------------------------------------------
// block_range_set
// Sorted table of disjoint, non-adjacent block ranges with merge on add.
// -----------------------------------------------------------------------------
//
//   word       direction  handshake                    payload
//   command    in         start high, busy low         cmd_i    (brs_cmd_t)
//   result     out        result_valid_o, one cycle    result_o (brs_result_t)
//
// A clear, an unknown opcode or a bad range goes straight to the result.
// A query reads the table one entry at a time until it reaches the first
// range that ends at or above the block, or the end of the stored ranges.
// An add scans, merges and shifts with one table read port and one write
// port, reading each entry it touches and writing those it moves.
// Reset empties the set at once; the table itself needs no clearing.
// The receiver cannot stall; busy stays high until the result is issued.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module block_range_set
  import brs_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  brs_cmd_t    cmd_i,
  output logic        result_valid_o,
  output brs_result_t result_o
);

  localparam int unsigned BW = BLOCK_BITS;
  localparam int unsigned TW = TOTAL_BITS;
  localparam int unsigned AW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_QRD  = 4'd1;
  localparam logic [3:0] S_QCK  = 4'd2;
  localparam logic [3:0] S_ARD  = 4'd3;
  localparam logic [3:0] S_ACK  = 4'd4;
  localparam logic [3:0] S_MRD  = 4'd5;
  localparam logic [3:0] S_MCK  = 4'd6;
  localparam logic [3:0] S_MWR  = 4'd7;
  localparam logic [3:0] S_SRD  = 4'd8;
  localparam logic [3:0] S_SWR  = 4'd9;
  localparam logic [3:0] S_INS  = 4'd10;
  localparam logic [3:0] S_ISTP = 4'd11;
  localparam logic [3:0] S_IWR  = 4'd12;
  localparam logic [3:0] S_RESP = 4'd13;

  // Range table: first block in the upper half, last block in the lower.
  logic [2*BW-1:0] range_mem [MAX_RANGES];
  logic [2*BW-1:0] rdata_q;

  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [2*BW-1:0] mem_wdata;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] used_q, used_d;
  logic [TW-1:0] cov_q, cov_d;
  logic [CW-1:0] idx_q, idx_d, lo_q, lo_d, hi_q, hi_d;
  logic [BW-1:0] s_q, s_d, e_q, e_d, b_q, b_d, nf_q, nf_d, nl_q, nl_d;
  logic [TW-1:0] gone_q, gone_d;
  logic [1:0]    status_q, status_d;
  logic          present_q, present_d;
  logic          rvalid_q, rvalid_d;
  brs_result_t   res_q, res_d;

  logic [BW-1:0] rd_f, rd_l;
  logic [BW:0]   rd_l_inc, e_inc;
  logic [TW-1:0] rd_len;
  logic [CW-1:0] idx_inc, idx_dec, removed, idx_src;

  assign rd_f     = rdata_q[2*BW-1:BW];
  assign rd_l     = rdata_q[BW-1:0];
  assign rd_l_inc = {1'b0, rd_l} + (BW+1)'(1);
  assign e_inc    = {1'b0, e_q} + (BW+1)'(1);
  assign rd_len   = TW'({1'b0, rd_l} - {1'b0, rd_f} + (BW+1)'(1));
  assign idx_inc  = idx_q + CW'(1);
  assign idx_dec  = idx_q - CW'(1);
  assign removed  = hi_q - lo_q;
  assign idx_src  = idx_q + removed;

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      range_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= range_mem[mem_raddr];
    end
  end

  // Sequencer: scan, merge, shift and insert over the table.
  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    cov_d     = cov_q;
    idx_d     = idx_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    s_d       = s_q;
    e_d       = e_q;
    b_d       = b_q;
    nf_d      = nf_q;
    nl_d      = nl_q;
    gone_d    = gone_q;
    status_d  = status_q;
    present_d = present_q;
    rvalid_d  = 1'b0;
    res_d     = res_q;
    mem_re    = 1'b0;
    mem_raddr = idx_q[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = rdata_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          s_d       = cmd_i.first_block;
          e_d       = cmd_i.last_block;
          b_d       = cmd_i.probe_block;
          status_d  = ST_DONE;
          present_d = 1'b0;
          idx_d     = '0;
          state_d   = S_RESP;
          case (cmd_i.opcode)
            OP_ADD: begin
              if (cmd_i.last_block < cmd_i.first_block) begin
                status_d = ST_BAD;
              end else if (used_q == '0) begin
                lo_d    = '0;
                state_d = S_INS;
              end else begin
                state_d = S_ARD;
              end
            end
            OP_QUERY: begin
              if (used_q != '0) begin
                state_d = S_QRD;
              end
            end
            OP_CLEAR: begin
              used_d = '0;
              cov_d  = '0;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      // Query: first range whose last block reaches the probe decides.
      S_QRD: begin
        mem_re  = 1'b1;
        state_d = S_QCK;
      end
      S_QCK: begin
        if (rd_l >= b_q) begin
          present_d = (rd_f <= b_q);
          state_d   = S_RESP;
        end else if (idx_inc == used_q) begin
          state_d = S_RESP;
        end else begin
          idx_d   = idx_inc;
          state_d = S_QRD;
        end
      end

      // Add: find the first range not entirely below first_block - 1.
      S_ARD: begin
        mem_re  = 1'b1;
        state_d = S_ACK;
      end
      S_ACK: begin
        if (rd_l_inc < {1'b0, s_q}) begin
          if (idx_inc == used_q) begin
            lo_d    = used_q;
            state_d = S_INS;
          end else begin
            idx_d   = idx_inc;
            state_d = S_ARD;
          end
        end else begin
          lo_d = idx_q;
          if ({1'b0, rd_f} > e_inc) begin
            state_d = S_INS;
          end else begin
            nf_d   = (rd_f < s_q) ? rd_f : s_q;
            nl_d   = (rd_l > e_q) ? rd_l : e_q;
            gone_d = rd_len;
            hi_d   = idx_q;
            if (idx_inc < used_q) begin
              idx_d   = idx_inc;
              state_d = S_MRD;
            end else begin
              state_d = S_MWR;
            end
          end
        end
      end

      // Merge: absorb following ranges that touch the new range.
      S_MRD: begin
        mem_re  = 1'b1;
        state_d = S_MCK;
      end
      S_MCK: begin
        if ({1'b0, rd_f} <= e_inc) begin
          hi_d   = idx_q;
          nl_d   = (rd_l > nl_q) ? rd_l : nl_q;
          gone_d = gone_q + rd_len;
          if (idx_inc < used_q) begin
            idx_d   = idx_inc;
            state_d = S_MRD;
          end else begin
            state_d = S_MWR;
          end
        end else begin
          state_d = S_MWR;
        end
      end
      S_MWR: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q[AW-1:0];
        mem_wdata = {nf_q, nl_q};
        cov_d     = cov_q - gone_q + TW'({1'b0, nl_q} - {1'b0, nf_q} + (BW+1)'(1));
        if (hi_q == lo_q) begin
          state_d = S_RESP;
        end else begin
          idx_d   = lo_q + CW'(1);
          state_d = S_SRD;
        end
      end

      // Close the gap left by the merged ranges.
      S_SRD: begin
        if (idx_src < used_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_src[AW-1:0];
          state_d   = S_SWR;
        end else begin
          used_d  = used_q - removed;
          state_d = S_RESP;
        end
      end
      S_SWR: begin
        mem_we  = 1'b1;
        idx_d   = idx_inc;
        state_d = S_SRD;
      end

      // Insert: open a slot at lo by shifting the tail up.
      S_INS: begin
        if (used_q == CW'(MAX_RANGES)) begin
          status_d = ST_FULL;
          state_d  = S_RESP;
        end else begin
          idx_d   = used_q;
          state_d = S_ISTP;
        end
      end
      S_ISTP: begin
        if (idx_q > lo_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
          state_d   = S_IWR;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = lo_q[AW-1:0];
          mem_wdata = {s_q, e_q};
          used_d    = used_q + CW'(1);
          cov_d     = cov_q + TW'({1'b0, e_q} - {1'b0, s_q} + (BW+1)'(1));
          state_d   = S_RESP;
        end
      end
      S_IWR: begin
        mem_we  = 1'b1;
        idx_d   = idx_dec;
        state_d = S_ISTP;
      end

      S_RESP: begin
        rvalid_d           = 1'b1;
        res_d.status       = status_q;
        res_d.present      = present_q;
        res_d.total_blocks = cov_q;
        res_d.range_count  = COUNT_BITS'(used_q);
        state_d            = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      cov_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      cov_q    <= cov_d;
      rvalid_q <= rvalid_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    s_q       <= s_d;
    e_q       <= e_d;
    b_q       <= b_d;
    nf_q      <= nf_d;
    nl_q      <= nl_d;
    gone_q    <= gone_d;
    status_q  <= status_d;
    present_q <= present_d;
    res_q     <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rvalid_q;
  assign result_o       = res_q;

  // Checks.
  `BRS_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `BRS_ASSERT(a_result_after_resp, clk_i, rst_ni, result_valid_o |-> $past(state_q == S_RESP))
  `BRS_ASSERT_NEVER(a_used_bound, clk_i, rst_ni, used_q > CW'(MAX_RANGES))
  `BRS_ASSERT(a_empty_zero, clk_i, rst_ni, (used_q == '0) |-> (cov_q == '0))

endmodule

// File: test/brs_checker.sv
// -----------------------------------------------------------------------------
// brs_checker
// Watches the command and result words of the block range set and compares
// every result with a prediction from a behavioral copy of the range table.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brs_checker
  import brs_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  brs_cmd_t    cmd_i,
  input  logic        result_valid_i,
  input  brs_result_t result_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o
);

  // Behavioral copy of the set: sorted, disjoint, non-adjacent ranges.
  logic [63:0] set_first[$];
  logic [63:0] set_last[$];
  logic [63:0] set_blocks;

  brs_result_t expected_results[$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Union of [s, e] into the set; returns the status code.
  function automatic logic [1:0] merge_span(input logic [63:0] s, input logic [63:0] e);
    int lo, hi;
    logic [63:0] nf, nl, gone;
    if (e < s) return ST_BAD;
    lo = 0;
    while (lo < set_first.size() && set_last[lo] + 1 < s) lo++;
    if (lo == set_first.size() || set_first[lo] > e + 1) begin
      if (set_first.size() >= MAX_RANGES) return ST_FULL;
      set_first.insert(lo, s);
      set_last.insert(lo, e);
      set_blocks += e - s + 1;
      return ST_DONE;
    end
    hi = lo;
    while (hi + 1 < set_first.size() && set_first[hi + 1] <= e + 1) hi++;
    nf = (set_first[lo] < s) ? set_first[lo] : s;
    nl = (set_last[hi] > e) ? set_last[hi] : e;
    gone = 0;
    for (int i = lo; i <= hi; i++) gone += set_last[i] - set_first[i] + 1;
    set_blocks = set_blocks - gone + (nl - nf + 1);
    for (int i = hi; i > lo; i--) begin
      set_first.delete(i);
      set_last.delete(i);
    end
    set_first[lo] = nf;
    set_last[lo] = nl;
    return ST_DONE;
  endfunction

  function automatic logic holds_block(input logic [63:0] b);
    foreach (set_first[i]) begin
      if (set_last[i] >= b) return set_first[i] <= b;
    end
    return 1'b0;
  endfunction

  // Predict on each accepted command word, compare each result word.
  always @(posedge clk_i or negedge rst_ni) begin
    brs_result_t predicted, want;
    if (!rst_ni) begin
      set_first.delete();
      set_last.delete();
      set_blocks = 0;
      expected_results.delete();
      fail_count_o = 0;
      results_seen_o = 0;
      pending_o = 0;
    end else begin
      if (result_valid_i) begin
        results_seen_o++;
        if (expected_results.size() == 0) begin
          $display("[%0t] result word with no command outstanding", $realtime);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (result_i.status !== want.status)
            report_mismatch("status", 64'(result_i.status), 64'(want.status));
          if (result_i.present !== want.present)
            report_mismatch("present", 64'(result_i.present), 64'(want.present));
          if (result_i.total_blocks !== want.total_blocks)
            report_mismatch("total_blocks", 64'(result_i.total_blocks),
                            64'(want.total_blocks));
          if (result_i.range_count !== want.range_count)
            report_mismatch("range_count", 64'(result_i.range_count),
                            64'(want.range_count));
        end
      end
      if (start_i && !busy_i) begin
        predicted = '0;
        case (cmd_i.opcode)
          OP_ADD: predicted.status = merge_span(64'(cmd_i.first_block),
                                                64'(cmd_i.last_block));
          OP_QUERY: predicted.present = holds_block(64'(cmd_i.probe_block));
          OP_CLEAR: begin
            set_first.delete();
            set_last.delete();
            set_blocks = 0;
          end
          default: ;
        endcase
        predicted.total_blocks = set_blocks[TOTAL_BITS-1:0];
        predicted.range_count = COUNT_BITS'(set_first.size());
        expected_results.push_back(predicted);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// File: test/tb_block_range_set.sv
// -----------------------------------------------------------------------------
// tb_block_range_set
// Drives directed and random add, query, clear and unknown-opcode commands into the block
// range set, with random gaps, and takes the verdict from the checker.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_block_range_set;
  import brs_pkg::*;

  localparam int unsigned MAX_RANGES = 64;
  localparam int RANDOM_WORDS = 865;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  brs_cmd_t    cmd_i = '0;
  logic        result_valid_o;
  brs_result_t result_o;
  int          fail_count, pending, results_seen;
  int          adds_sent, queries_sent, clears_sent;

  always #5 clk_i = ~clk_i;

  block_range_set #(.MAX_RANGES(MAX_RANGES)) dut (
    .clk_i, .rst_ni, .start(start_i), .busy(busy_o), .cmd_i,
    .result_valid_o, .result_o
  );

  brs_checker #(.MAX_RANGES(MAX_RANGES)) checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .cmd_i,
    .result_valid_i(result_valid_o), .result_i(result_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  // Send one command word after a random gap; returns once the block has accepted it.
  task automatic send_word(input logic [1:0] op, input logic [31:0] f,
                           input logic [31:0] l, input logic [31:0] p);
    brs_cmd_t w;
    int gap;
    w.opcode = op;
    w.first_block = f;
    w.last_block = l;
    w.probe_block = p;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    repeat (gap) @(posedge clk_i);
    start_i <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy_o);
    start_i <= 1'b0;
    cmd_i <= {2'($urandom), $urandom, $urandom, $urandom};
    case (op)
      OP_ADD: adds_sent++;
      OP_QUERY: queries_sent++;
      OP_CLEAR: clears_sent++;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Random block near a small window so ranges collide, touch and merge.
  function automatic logic [31:0] pick_block(input logic [31:0] window);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: return $urandom_range(0, window);
    endcase
  endfunction

  initial begin
    logic [31:0] a, b, window;
    int kind;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, merging, adjacency, bad range, unknown opcode.
    send_word(OP_QUERY, 0, 0, 0);
    send_word(OP_ADD, 10, 20, 0);
    send_word(OP_ADD, 12, 15, 0);
    send_word(OP_ADD, 21, 25, 0);
    send_word(OP_ADD, 30, 40, 0);
    send_word(OP_ADD, 27, 28, 0);
    send_word(OP_ADD, 26, 29, 0);
    send_word(OP_ADD, 5, 3, 0);
    send_word(OP_QUERY, 0, 0, 40);
    send_word(OP_QUERY, 0, 0, 41);
    send_word(OP_QUERY, 0, 0, 9);
    send_word(OP_RSVD, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    send_word(OP_ADD, 0, 32'hFFFF_FFFF, 0);
    send_word(OP_QUERY, 0, 0, 32'hFFFF_FFFF);
    send_word(OP_CLEAR, 0, 0, 0);
    send_word(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(OP_ADD, 0, 0, 0);
    send_word(OP_QUERY, 0, 0, 32'hFFFF_FFFE);
    // Fill the table with isolated ranges, then hit the full case.
    for (int i = 1; i < MAX_RANGES; i++) send_word(OP_ADD, 4 * i, 4 * i + 1, 0);
    send_word(OP_ADD, 1000, 1000, 0);
    send_word(OP_ADD, 6, 6, 0);
    send_word(OP_QUERY, 0, 0, 4 * 33);

    // Let the block drain completely once.
    wait (pending == 0);
    send_word(OP_CLEAR, 0, 0, 0);

    // Random: mostly adds and queries in a shifting window, rare clears.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      window = (n % 300 < 150) ? 32'd300 : 32'd5000;
      kind = $urandom_range(0, 99);
      a = pick_block(window);
      b = ($urandom_range(0, 9) == 0) ? pick_block(window) : a + $urandom_range(0, 20);
      if (b < a && $urandom_range(0, 1)) b = a;
      if (kind < 55) send_word(OP_ADD, a, b, $urandom);
      else if (kind < 93) send_word(OP_QUERY, $urandom, $urandom, pick_block(window));
      else if (kind < 97) send_word(OP_CLEAR, $urandom, $urandom, $urandom);
      else send_word(OP_RSVD, $urandom, $urandom, $urandom);
    end

    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d adds, %0d queries, %0d clears; %0d results checked.",
             adds_sent, queries_sent, clears_sent, results_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #20ms;
    $display("Timed out.");
    $display("== FAIL ==");
    $finish;
  end

endmodule
